### rtl/dnsa_pkg.sv
// Shared types and constants for the DNS response A-record parser.
`default_nettype none

package dnsa_pkg;

    // Parse phases
    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_QLEN   = 4'd1,
        PH_QLABEL = 4'd2,
        PH_QFIX   = 4'd3,
        PH_ANAME  = 4'd4,
        PH_APTR   = 4'd5,
        PH_ALABEL = 4'd6,
        PH_ALEN   = 4'd7,
        PH_AFIX   = 4'd8,
        PH_ASKIP  = 4'd9,
        PH_ADDR   = 4'd10,
        PH_IGNORE = 4'd11
    } phase_t;

    localparam logic [15:0] ID_RESET     = 16'h1234;
    localparam logic [7:0]  PTR_MASK     = 8'hC0;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] ADDR_LEN     = 16'd4;
    localparam logic [15:0] QFIX_LEN     = 16'd4;

    // Byte positions inside the header and the fixed answer fields
    localparam logic [3:0]  HDR_ID_END   = 4'd2;
    localparam logic [3:0]  HDR_QD_HI    = 4'd4;
    localparam logic [3:0]  HDR_QD_LO    = 4'd5;
    localparam logic [3:0]  HDR_AN_HI    = 4'd6;
    localparam logic [3:0]  HDR_AN_LO    = 4'd7;
    localparam logic [3:0]  HDR_LAST     = 4'd11;
    localparam logic [3:0]  AFIX_TYPE_END = 4'd2;
    localparam logic [3:0]  AFIX_LEN_HI  = 4'd8;
    localparam logic [3:0]  AFIX_LAST    = 4'd9;

    // One input beat
    typedef struct packed {
        logic       last;
        logic [7:0] payload_byte;
    } beat_t;

    // One result item
    typedef struct packed {
        logic        found;
        logic [31:0] address;
    } result_t;

endpackage

`default_nettype wire

### rtl/dnsa_in_reg.sv
// Input register stage: holds one payload beat until the parser takes it.
`default_nettype none

module dnsa_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dnsa_pkg::beat_t in_beat,
    output logic               out_valid,
    input  wire logic          out_take,
    output dnsa_pkg::beat_t    out_beat
);

    logic            valid_reg;
    dnsa_pkg::beat_t beat_reg;

    // Free when empty or when the held beat leaves this cycle
    assign in_ready  = !valid_reg || out_take;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Beat payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

`default_nettype wire

### rtl/dnsa_parser.sv
// Byte-wise DNS response parse state and A-record capture.
`default_nettype none

module dnsa_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [15:0]     cfg_data,
    input  wire logic            in_valid,
    output logic                 in_take,
    input  wire dnsa_pkg::beat_t in_beat,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output dnsa_pkg::result_t    res
);

    localparam logic [32:0] SKIP_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    logic [15:0]            expected_id_reg;
    dnsa_pkg::phase_t       phase_reg, phase_next;
    logic [3:0]             idx_reg, idx_next;
    logic [15:0]            questions_left_reg, questions_left_next;
    logic [15:0]            answers_left_reg, answers_left_next;
    logic [LENGTH_BITS-1:0] skip_left_reg, skip_left_next;
    logic [15:0]            record_type_reg, record_type_next;
    logic [15:0]            record_length_reg, record_length_next;
    logic [31:0]            address_shift_reg, address_shift_next;
    logic                   matched_reg, matched_next;
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] skip_dec;

    // Skip counter load, saturating at the counter's full scale
    function automatic logic [LENGTH_BITS-1:0] skip_load(input logic [15:0] v);
        logic [32:0] wide;
        logic [32:0] sat;
        wide = {17'd0, v};
        sat  = (wide > SKIP_MAX) ? SKIP_MAX : wide;
        return sat[LENGTH_BITS-1:0];
    endfunction

    assign b        = in_beat.payload_byte;
    assign skip_dec = skip_left_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    // A last beat needs room in the result register
    assign in_take   = in_valid && (!in_beat.last || res_ready);
    assign res_valid = in_valid && in_beat.last;
    assign res.found   = matched_next;
    assign res.address = matched_next ? address_shift_next : 32'd0;

    assign cfg_ready = 1'b1;

    // Expected transaction id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= dnsa_pkg::ID_RESET;
        end
        else if (cfg_valid)
        begin
            expected_id_reg <= cfg_data;
        end
    end

    // Next parse state for the byte at the input
    always_comb
    begin
        phase_next          = phase_reg;
        idx_next            = idx_reg;
        questions_left_next = questions_left_reg;
        answers_left_next   = answers_left_reg;
        skip_left_next      = skip_left_reg;
        record_type_next    = record_type_reg;
        record_length_next  = record_length_reg;
        address_shift_next  = address_shift_reg;
        matched_next        = matched_reg;

        unique case (phase_reg)
            dnsa_pkg::PH_HDR:
            begin
                if (idx_reg < dnsa_pkg::HDR_ID_END)
                begin
                    record_type_next = {record_type_reg[7:0], b};
                end
                else if (idx_reg == dnsa_pkg::HDR_QD_HI || idx_reg == dnsa_pkg::HDR_QD_LO)
                begin
                    questions_left_next = {questions_left_reg[7:0], b};
                end
                else if (idx_reg == dnsa_pkg::HDR_AN_HI || idx_reg == dnsa_pkg::HDR_AN_LO)
                begin
                    answers_left_next = {answers_left_reg[7:0], b};
                end
                idx_next = idx_reg + 4'd1;
                if (idx_reg == dnsa_pkg::HDR_LAST)
                begin
                    idx_next = 4'd0;
                    if (record_type_reg != expected_id_reg || answers_left_reg == 16'd0)
                    begin
                        phase_next = dnsa_pkg::PH_IGNORE;
                    end
                    else if (questions_left_reg != 16'd0)
                    begin
                        phase_next = dnsa_pkg::PH_QLEN;
                    end
                    else
                    begin
                        phase_next = dnsa_pkg::PH_ANAME;
                    end
                end
            end
            dnsa_pkg::PH_QLEN:
            begin
                if (b == 8'd0)
                begin
                    phase_next     = dnsa_pkg::PH_QFIX;
                    skip_left_next = skip_load(dnsa_pkg::QFIX_LEN);
                end
                else
                begin
                    skip_left_next = skip_load({8'd0, b});
                    phase_next     = dnsa_pkg::PH_QLABEL;
                end
            end
            dnsa_pkg::PH_QLABEL:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = dnsa_pkg::PH_QLEN;
                end
            end
            dnsa_pkg::PH_QFIX:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == '0)
                begin
                    questions_left_next = questions_left_reg - 16'd1;
                    phase_next = (questions_left_reg == 16'd1) ? dnsa_pkg::PH_ANAME
                                                               : dnsa_pkg::PH_QLEN;
                end
            end
            dnsa_pkg::PH_ANAME:
            begin
                if ((b & dnsa_pkg::PTR_MASK) == dnsa_pkg::PTR_MASK)
                begin
                    phase_next = dnsa_pkg::PH_APTR;
                end
                else if (b == 8'd0)
                begin
                    phase_next = dnsa_pkg::PH_AFIX;
                    idx_next   = 4'd0;
                end
                else
                begin
                    skip_left_next = skip_load({8'd0, b});
                    phase_next     = dnsa_pkg::PH_ALABEL;
                end
            end
            dnsa_pkg::PH_APTR:
            begin
                phase_next = dnsa_pkg::PH_AFIX;
                idx_next   = 4'd0;
            end
            dnsa_pkg::PH_ALABEL:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = dnsa_pkg::PH_ALEN;
                end
            end
            dnsa_pkg::PH_ALEN:
            begin
                if (b == 8'd0)
                begin
                    phase_next = dnsa_pkg::PH_AFIX;
                    idx_next   = 4'd0;
                end
                else
                begin
                    skip_left_next = skip_load({8'd0, b});
                    phase_next     = dnsa_pkg::PH_ALABEL;
                end
            end
            dnsa_pkg::PH_AFIX:
            begin
                if (idx_reg < dnsa_pkg::AFIX_TYPE_END)
                begin
                    record_type_next = {record_type_reg[7:0], b};
                end
                else if (idx_reg >= dnsa_pkg::AFIX_LEN_HI)
                begin
                    record_length_next = {record_length_reg[7:0], b};
                end
                idx_next = idx_reg + 4'd1;
                if (idx_reg >= dnsa_pkg::AFIX_LAST)
                begin
                    idx_next = 4'd0;
                    if (record_type_reg == dnsa_pkg::TYPE_A
                        && record_length_next == dnsa_pkg::ADDR_LEN)
                    begin
                        phase_next         = dnsa_pkg::PH_ADDR;
                        address_shift_next = 32'd0;
                    end
                    else if (record_length_next == 16'd0)
                    begin
                        // Empty rdata: straight on to the next answer, or to the ignore phase after the last one
                        answers_left_next = answers_left_reg - 16'd1;
                        phase_next = (answers_left_reg == 16'd1) ? dnsa_pkg::PH_IGNORE
                                                                 : dnsa_pkg::PH_ANAME;
                    end
                    else
                    begin
                        skip_left_next = skip_load(record_length_next);
                        phase_next     = dnsa_pkg::PH_ASKIP;
                    end
                end
            end
            dnsa_pkg::PH_ASKIP:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == '0)
                begin
                    answers_left_next = answers_left_reg - 16'd1;
                    phase_next = (answers_left_reg == 16'd1) ? dnsa_pkg::PH_IGNORE
                                                             : dnsa_pkg::PH_ANAME;
                end
            end
            dnsa_pkg::PH_ADDR:
            begin
                address_shift_next = {address_shift_reg[23:0], b};
                idx_next           = idx_reg + 4'd1;
                if ((idx_reg + 4'd1) >= dnsa_pkg::ADDR_LEN[3:0])
                begin
                    matched_next = 1'b1;
                    phase_next   = dnsa_pkg::PH_IGNORE;
                end
            end
            default:
            begin
                // Ignore phase: hold everything until the last beat
            end
        endcase
    end

    // Parse state; a last beat restarts at the header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= dnsa_pkg::PH_HDR;
            idx_reg            <= '0;
            questions_left_reg <= '0;
            answers_left_reg   <= '0;
            skip_left_reg      <= '0;
            record_type_reg    <= '0;
            record_length_reg  <= '0;
            address_shift_reg  <= '0;
            matched_reg        <= 1'b0;
        end
        else if (in_take)
        begin
            if (in_beat.last)
            begin
                phase_reg          <= dnsa_pkg::PH_HDR;
                idx_reg            <= '0;
                questions_left_reg <= '0;
                answers_left_reg   <= '0;
                skip_left_reg      <= '0;
                record_type_reg    <= '0;
                record_length_reg  <= '0;
                address_shift_reg  <= '0;
                matched_reg        <= 1'b0;
            end
            else
            begin
                phase_reg          <= phase_next;
                idx_reg            <= idx_next;
                questions_left_reg <= questions_left_next;
                answers_left_reg   <= answers_left_next;
                skip_left_reg      <= skip_left_next;
                record_type_reg    <= record_type_next;
                record_length_reg  <= record_length_next;
                address_shift_reg  <= address_shift_next;
                matched_reg        <= matched_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // A taken last beat always leaves a fresh parser behind
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && in_beat.last |=> phase_reg == dnsa_pkg::PH_HDR && !matched_reg)
        else $error("parser did not restart after last beat");

    // Once captured, the parser only waits for the end of the packet
    a_match_idle: assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg |-> phase_reg == dnsa_pkg::PH_IGNORE)
        else $error("matched outside the ignore phase");

    // Counting phases never hold an exhausted skip counter
    a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dnsa_pkg::PH_QLABEL || phase_reg == dnsa_pkg::PH_QFIX
         || phase_reg == dnsa_pkg::PH_ALABEL || phase_reg == dnsa_pkg::PH_ASKIP)
        |-> skip_left_reg != '0)
        else $error("skip counter empty in a skip phase");

    // Byte index stays within the header and fixed answer fields
    a_hdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dnsa_pkg::PH_HDR |-> idx_reg <= dnsa_pkg::HDR_LAST)
        else $error("header byte index out of range");

    a_afix_idx: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dnsa_pkg::PH_AFIX |-> idx_reg <= dnsa_pkg::AFIX_LAST)
        else $error("answer field index out of range");
`endif

endmodule

`default_nettype wire

### rtl/dnsa_out_reg.sv
// Result register: holds one result beat until the sink takes it.
`default_nettype none

module dnsa_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dnsa_pkg::result_t in_res,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dnsa_pkg::result_t      out_res
);

    logic              valid_reg;
    dnsa_pkg::result_t res_reg;

    // Takes a new result when empty or while the held one leaves
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_res;
        end
    end

endmodule

`default_nettype wire

### rtl/dns_response_a_record_parser_top.sv
// Top level of the DNS response A-record parser.
`default_nettype none

// Takes a DNS response one byte per beat on the slave stream, tlast on the
// final byte, and on that byte returns one result beat: tuser is found, tdata
// the first type-A address with rdlength 4 (zero when not found). Bytes are
// accepted at one per cycle, sustained; the per-byte parse update sits
// between the input and result registers, which a result passes through
// after its last byte is accepted. Input stalls only when a last byte meets
// a result still waiting in the result register. expected_id resets to 0x1234
// with no clearing pass; the user must write it through the cfg channel
// (always ready) while no packet is in flight; the block does not enforce it.

module dns_response_a_record_parser_top #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] address
    output logic             m_axis_tuser,   // [0] found
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    dnsa_pkg::beat_t   s_beat;
    dnsa_pkg::beat_t   held_beat;
    logic              held_valid;
    logic              held_take;
    logic              res_valid;
    logic              res_ready;
    dnsa_pkg::result_t res;
    dnsa_pkg::result_t m_res;

    assign s_beat.payload_byte = s_axis_tdata;
    assign s_beat.last         = s_axis_tlast;

    // Input register
    dnsa_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_beat   (s_beat),
        .out_valid (held_valid),
        .out_take  (held_take),
        .out_beat  (held_beat)
    );

    // Parse logic
    dnsa_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (held_valid),
        .in_take   (held_take),
        .in_beat   (held_beat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Result register
    dnsa_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (m_res)
    );

    assign m_axis_tdata = m_res.address;
    assign m_axis_tuser = m_res.found;

endmodule

`default_nettype wire

### tb/dns_response_a_record_parser_top_tb.sv
// Testbench for the DNS response A-record parser: packet stimulus, byte-level prediction, checks.
`timescale 1ns / 1ps

module dns_response_a_record_parser_top_tb;
    import dnsa_pkg::*;

    localparam int LEN_BITS = 16;
    localparam int DRAIN    = 6;       // idle cycles before an id write
    localparam int CALM_LEN = 150;     // last bytes go out with no idling
    localparam int LIMIT    = 400000;

    // One pending stimulus entry: either a payload beat or an id write
    typedef struct {
        bit          is_id_write;
        logic [7:0]  payload;
        logic        tl;
        logic [15:0] new_id;
    } feed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    feed_t       feed_q[$];
    result_t     lookup_results_q[$];
    logic [7:0]  pkt[$];

    // Predictor state
    phase_t              ph;
    logic [3:0]          fld_idx;
    logic [15:0]         q_left;
    logic [15:0]         a_left;
    logic [LEN_BITS-1:0] skip_cnt;
    logic [15:0]         rr_type;
    logic [15:0]         rr_len;
    logic [31:0]         addr_acc;
    logic                got_addr;
    logic [15:0]         cur_id;

    int  err_count = 0;
    int  cycle_count = 0;
    int  sent_bytes = 0;
    int  pkt_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  quiet = 0;
    logic calm = 1'b0;

    dns_response_a_record_parser_top #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------

    // Label and rdata lengths saturate to the width of the skip counter
    function automatic logic [LEN_BITS-1:0] fit_skip(input logic [15:0] v);
        logic [63:0] cap;
        logic [63:0] w;
        cap = (64'd1 << LEN_BITS) - 64'd1;
        w = 64'(v);
        if (w > cap)
            w = cap;
        return w[LEN_BITS-1:0];
    endfunction

    task automatic restart_parse();
        ph       = PH_HDR;
        fld_idx  = '0;
        q_left   = '0;
        a_left   = '0;
        skip_cnt = '0;
        rr_type  = '0;
        rr_len   = '0;
        addr_acc = '0;
        got_addr = 1'b0;
    endtask

    task automatic drop_answer();
        a_left = a_left - 16'd1;
        ph = (a_left == 16'd0) ? PH_IGNORE : PH_ANAME;
    endtask

    // Advance the parse by one accepted byte; on tlast queue the lookup result
    task automatic parse_dns_byte(input logic [7:0] b, input logic tl);
        logic [3:0] i;
        result_t    r;
        case (ph)
            PH_HDR:
            begin
                i = fld_idx;
                if (i < HDR_ID_END)
                    rr_type = {rr_type[7:0], b};
                else if (i == HDR_QD_HI || i == HDR_QD_LO)
                    q_left = {q_left[7:0], b};
                else if (i == HDR_AN_HI || i == HDR_AN_LO)
                    a_left = {a_left[7:0], b};
                fld_idx = i + 4'd1;
                if (i == HDR_LAST)
                begin
                    fld_idx = '0;
                    if (rr_type != cur_id || a_left == 16'd0)
                        ph = PH_IGNORE;
                    else
                        ph = (q_left != 16'd0) ? PH_QLEN : PH_ANAME;
                end
            end
            PH_QLEN:
            begin
                if (b == 8'd0)
                begin
                    ph = PH_QFIX;
                    skip_cnt = fit_skip(QFIX_LEN);
                end
                else
                begin
                    skip_cnt = fit_skip({8'd0, b});
                    ph = PH_QLABEL;
                end
            end
            PH_QLABEL:
            begin
                skip_cnt = skip_cnt - 1'b1;
                if (skip_cnt == '0)
                    ph = PH_QLEN;
            end
            PH_QFIX:
            begin
                skip_cnt = skip_cnt - 1'b1;
                if (skip_cnt == '0)
                begin
                    q_left = q_left - 16'd1;
                    ph = (q_left == 16'd0) ? PH_ANAME : PH_QLEN;
                end
            end
            PH_ANAME:
            begin
                if ((b & PTR_MASK) == PTR_MASK)
                    ph = PH_APTR;
                else if (b == 8'd0)
                begin
                    ph = PH_AFIX;
                    fld_idx = '0;
                end
                else
                begin
                    skip_cnt = fit_skip({8'd0, b});
                    ph = PH_ALABEL;
                end
            end
            PH_APTR:
            begin
                ph = PH_AFIX;
                fld_idx = '0;
            end
            PH_ALABEL:
            begin
                skip_cnt = skip_cnt - 1'b1;
                if (skip_cnt == '0)
                    ph = PH_ALEN;
            end
            PH_ALEN:
            begin
                // only the first byte of an answer name may be a pointer
                if (b == 8'd0)
                begin
                    ph = PH_AFIX;
                    fld_idx = '0;
                end
                else
                begin
                    skip_cnt = fit_skip({8'd0, b});
                    ph = PH_ALABEL;
                end
            end
            PH_AFIX:
            begin
                i = fld_idx;
                if (i < AFIX_TYPE_END)
                    rr_type = {rr_type[7:0], b};
                else if (i >= AFIX_LEN_HI)
                    rr_len = {rr_len[7:0], b};
                fld_idx = i + 4'd1;
                if (i >= AFIX_LAST)
                begin
                    fld_idx = '0;
                    if (rr_type == TYPE_A && rr_len == ADDR_LEN)
                    begin
                        ph = PH_ADDR;
                        addr_acc = '0;
                    end
                    else if (rr_len == 16'd0)
                        drop_answer();
                    else
                    begin
                        skip_cnt = fit_skip(rr_len);
                        ph = PH_ASKIP;
                    end
                end
            end
            PH_ASKIP:
            begin
                skip_cnt = skip_cnt - 1'b1;
                if (skip_cnt == '0)
                    drop_answer();
            end
            PH_ADDR:
            begin
                addr_acc = {addr_acc[23:0], b};
                fld_idx = fld_idx + 4'd1;
                if ({12'd0, fld_idx} >= ADDR_LEN)
                begin
                    got_addr = 1'b1;
                    ph = PH_IGNORE;
                end
            end
            default:
            begin
            end
        endcase
        if (tl)
        begin
            r.found   = got_addr;
            r.address = got_addr ? addr_acc : 32'd0;
            lookup_results_q.push_back(r);
            restart_parse();
        end
    endtask

    // ---------------- packet builders ----------------

    task automatic put(input logic [7:0] b);
        pkt.push_back(b);
    endtask

    task automatic put16(input logic [15:0] v);
        put(v[15:8]);
        put(v[7:0]);
    endtask

    task automatic put_header(input logic [15:0] id, input logic [15:0] qd,
                              input logic [15:0] an);
        put16(id);
        put16(16'($urandom));
        put16(qd);
        put16(an);
        put16(16'($urandom));
        put16(16'($urandom));
    endtask

    task automatic put_labels(input int nlab, input int maxlen);
        int n;
        repeat (nlab)
        begin
            n = $urandom_range(1, maxlen);
            put(8'(n));
            repeat (n) put(8'($urandom));
        end
        put(8'h00);
    endtask

    task automatic put_question();
        put_labels($urandom_range(0, 3), 6);
        put16(16'($urandom));
        put16(16'($urandom));
    endtask

    // kind: 0 pointer name, 1 label run, 2 root name, else name already written
    task automatic put_answer(input int kind, input logic [15:0] t, input logic [15:0] l,
                              input int fill);
        case (kind)
            0:
            begin
                put(PTR_MASK | 8'($urandom_range(0, 63)));
                put(8'($urandom));
            end
            1: put_labels($urandom_range(1, 3), 6);
            2: put(8'h00);
            default:
            begin
            end
        endcase
        put16(t);
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'($urandom));
        put16(l);
        repeat (l) put((fill < 0) ? 8'($urandom) : 8'(fill));
    endtask

    // Move the first keep bytes of the built packet into the feed, tlast on the final one
    task automatic emit(input int keep);
        feed_t f;
        if (keep > pkt.size())
            keep = pkt.size();
        for (int k = 0; k < keep; k++)
        begin
            f.is_id_write = 1'b0;
            f.payload     = pkt[k];
            f.tl          = (k == keep - 1);
            f.new_id      = '0;
            feed_q.push_back(f);
        end
        sent_bytes += keep;
        pkt_count++;
        pkt.delete();
    endtask

    task automatic emit_id(input logic [15:0] v);
        feed_t f;
        f.is_id_write = 1'b1;
        f.payload     = '0;
        f.tl          = 1'b0;
        f.new_id      = v;
        feed_q.push_back(f);
    endtask

    task automatic good_packet(input logic [15:0] id, input bit cut);
        int qd;
        int an;
        int an_claim;
        logic [15:0] t;
        logic [15:0] l;
        qd = $urandom_range(0, 2);
        an = $urandom_range(1, 3);
        an_claim = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : an;
        put_header(id, 16'(qd), 16'(an_claim));
        repeat (qd) put_question();
        repeat (an)
        begin
            t = ($urandom_range(0, 5) < 3) ? TYPE_A : 16'($urandom);
            case ($urandom_range(0, 5))
                0, 1, 2: l = ADDR_LEN;
                3:       l = 16'd0;
                default: l = 16'($urandom_range(1, 8));
            endcase
            put_answer($urandom_range(0, 2), t, l, -1);
        end
        repeat ($urandom_range(0, 3)) put(8'($urandom));
        if (cut)
            emit($urandom_range(1, pkt.size()));
        else
            emit(pkt.size());
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            cfg_valid     <= 1'b0;
            cfg_data      <= '0;
            calm          <= 1'b0;
            gap_left = 0;
            quiet = 0;
            cur_id = ID_RESET;
            restart_parse();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_dns_byte(s_axis_tdata, s_axis_tlast);
            if (cfg_valid && cfg_ready)
                cur_id = cfg_data;
            calm <= (feed_q.size() < CALM_LEN);
            quiet = (lookup_results_q.size() == 0 && !s_axis_tvalid) ? quiet + 1 : 0;

            if ((s_axis_tvalid && !s_axis_tready) || (cfg_valid && !cfg_ready))
            begin
                // beat still waiting, hold it
            end
            else if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                cfg_valid     <= 1'b0;
                gap_left--;
            end
            else if (feed_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                cfg_valid     <= 1'b0;
            end
            else if (feed_q[0].is_id_write)
            begin
                // id writes only once the parser has drained
                s_axis_tvalid <= 1'b0;
                if (quiet >= DRAIN)
                begin
                    cfg_valid <= 1'b1;
                    cfg_data  <= feed_q[0].new_id;
                    void'(feed_q.pop_front());
                end
                else
                    cfg_valid <= 1'b0;
            end
            else
            begin
                cfg_valid <= 1'b0;
                if (!calm && $urandom_range(0, 5) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    gap_left = $urandom_range(0, 7);
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= feed_q[0].payload;
                    s_axis_tlast  <= feed_q[0].tl;
                    void'(feed_q.pop_front());
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want_v);
        $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want_v);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (lookup_results_q.size() == 0)
                    report("result beat with nothing pending", m_axis_tdata, 32'd0);
                else
                begin
                    want = lookup_results_q.pop_front();
                    if (m_axis_tuser !== want.found)
                        report("found", {31'd0, m_axis_tuser}, {31'd0, want.found});
                    if (m_axis_tdata !== want.address)
                        report("address", m_axis_tdata, want.address);
                end
            end

            // receiver stalls in bursts
            if (calm)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("dns_response_a_record_parser_top: mismatch");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial
    begin
        logic [15:0] gen_id;
        int base_bytes;
        int base_pkts;
        int shape;

        gen_id = ID_RESET;

        // short packets
        put(8'hFF);
        emit(pkt.size());
        put_header(gen_id, 16'd0, 16'd1);
        emit(11);
        put_header(gen_id, 16'd0, 16'd1);
        emit(12);
        // id mismatch and zero answers
        put_header(~gen_id, 16'd0, 16'd1);
        put_answer(0, TYPE_A, ADDR_LEN, -1);
        emit(pkt.size());
        put_header(gen_id, 16'd1, 16'd0);
        put_question();
        put_answer(0, TYPE_A, ADDR_LEN, -1);
        emit(pkt.size());
        // pointer name, all-ones address
        put_header(gen_id, 16'd0, 16'd1);
        put_answer(0, TYPE_A, ADDR_LEN, 255);
        emit(pkt.size());
        // label names, zero address, bytes after the match
        put_header(gen_id, 16'd1, 16'd1);
        put_question();
        put_answer(1, TYPE_A, ADDR_LEN, 0);
        repeat (3) put(8'($urandom));
        emit(pkt.size());
        // truncated inside the address
        put_header(gen_id, 16'd0, 16'd1);
        put_answer(2, TYPE_A, ADDR_LEN, -1);
        emit(pkt.size() - 1);
        // wrong length, wrong type, then a match
        put_header(gen_id, 16'd0, 16'd3);
        put_answer(2, TYPE_A, 16'd8, -1);
        put_answer(0, 16'd28, ADDR_LEN, -1);
        put_answer(1, TYPE_A, ADDR_LEN, -1);
        emit(pkt.size());
        // empty rdata then a match
        put_header(gen_id, 16'd0, 16'd2);
        put_answer(0, 16'd5, 16'd0, -1);
        put_answer(0, TYPE_A, ADDR_LEN, -1);
        emit(pkt.size());
        // label lengths with the top two bits set, in a question and inside an answer name
        put_header(gen_id, 16'd1, 16'd1);
        put(8'hC3);
        repeat (195) put(8'($urandom));
        put(8'h00);
        put16(16'($urandom));
        put16(16'($urandom));
        put(8'h05);
        repeat (5) put(8'($urandom));
        put(8'hC2);
        repeat (194) put(8'($urandom));
        put(8'h00);
        put_answer(3, TYPE_A, ADDR_LEN, -1);
        emit(pkt.size());
        // answers run out with no A record
        put_header(gen_id, 16'd0, 16'd2);
        put_answer(0, 16'd16, 16'd2, -1);
        put_answer(2, 16'd5, ADDR_LEN, -1);
        repeat (10) put(8'($urandom));
        emit(pkt.size());
        // largest counts
        put_header(gen_id, 16'hFFFF, 16'hFFFF);
        repeat (20) put(8'($urandom));
        emit(pkt.size());
        // id register extremes
        gen_id = 16'h0000;
        emit_id(gen_id);
        good_packet(gen_id, 1'b0);
        good_packet(gen_id, 1'b0);
        gen_id = 16'hFFFF;
        emit_id(gen_id);
        good_packet(gen_id, 1'b0);
        good_packet(16'h0000, 1'b0);

        // random part: mostly well-formed packets, some broken ones and noise
        base_bytes = sent_bytes;
        base_pkts  = pkt_count;
        while (sent_bytes - base_bytes < 600 || pkt_count - base_pkts < 48)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                gen_id = 16'($urandom);
                emit_id(gen_id);
            end
            shape = $urandom_range(0, 99);
            if (shape < 70)
                good_packet(gen_id, 1'b0);
            else if (shape < 78)
                good_packet(16'($urandom), 1'b0);
            else if (shape < 85)
            begin
                put_header(gen_id, 16'($urandom_range(0, 2)), 16'd0);
                repeat ($urandom_range(0, 20)) put(8'($urandom));
                emit(pkt.size());
            end
            else if (shape < 90)
            begin
                repeat ($urandom_range(1, 40)) put(8'($urandom));
                emit(pkt.size());
            end
            else if (shape < 95)
            begin
                put_header(gen_id, 16'($urandom_range(0, 3)), 16'($urandom_range(1, 3)));
                repeat ($urandom_range(1, 30)) put(8'($urandom));
                emit(pkt.size());
            end
            else
                good_packet(gen_id, 1'b1);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || s_axis_tvalid || cfg_valid || lookup_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (err_count == 0)
            $display("dns_response_a_record_parser_top: match");
        else
            $display("dns_response_a_record_parser_top: mismatch");
        $finish;
    end

endmodule
